/* sv/pid_speed_drive_with_feedforward_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the speed drive controller
// Shared immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef PID_SPEED_DRIVE_WITH_FEEDFORWARD_ASSERT_SVH
`define PID_SPEED_DRIVE_WITH_FEEDFORWARD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/psd_pkg.sv */
// ----------------------------------------------------------------------------
// Speed drive controller package
// Payload types, configuration types and reset values shared by the block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int GAIN_W   = 16;
    localparam int ILIM_W   = 16;
    localparam int OLIM_W   = 15;
    localparam int SPEED_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ILIM_W-1:0] ILIM_RESET = 16'd1000;
    localparam logic [OLIM_W-1:0] OLIM_RESET = 15'd9800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF_GAIN  = 3'd0,
        CFG_P_GAIN   = 3'd1,
        CFG_I_GAIN   = 3'd2,
        CFG_D_GAIN   = 3'd3,
        CFG_ILIMIT   = 3'd4,
        CFG_OLIMIT   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target;
        logic signed [SPEED_W-1:0] measure;
    } t_in;

    typedef struct packed {
        logic signed [SPEED_W-1:0] drive;
        logic                      direction;
        logic [OLIM_W-1:0]         magnitude;
        logic                      reversal;
    } t_out;

    typedef struct packed {
        logic signed [GAIN_W-1:0] ff_gain;
        logic signed [GAIN_W-1:0] p_gain;
        logic signed [GAIN_W-1:0] i_gain;
        logic signed [GAIN_W-1:0] d_gain;
        logic [ILIM_W-1:0]        integral_limit;
        logic [OLIM_W-1:0]        output_limit;
    } t_cfg;

endpackage

/* sv/pid_speed_drive_with_feedforward.sv */
// ----------------------------------------------------------------------------
// PID speed drive with feedforward, one motor channel
// Positional PID with saturated integral and output, plus H-bridge direction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall  t_in  {target, measure}
//  out       source     o_out_valid / i_out_stall t_out {drive, direction,
//                                                        magnitude, reversal}
//  cfg       sink       i_cfg_valid / o_cfg_ready index 0..5, 16-bit data
//
// One transaction is accepted per cycle when the pipeline is not backed up.
// The pipeline runs through the input register, error stage, product stage and
// the result register, where the sum, floor shift and clamp are formed.
// The loop state (error sum, previous error) advances as a transaction leaves
// the input register, so back-to-back transactions see each other's state.
// Reset is synchronous and active low; it clears the loop state, the stage
// valid bits and loads the register reset values. No clearing pass is needed.
// A stall on the result side only blocks stages that are full, so bubbles
// in the pipeline keep being filled while a result waits.
// ----------------------------------------------------------------------------
module pid_speed_drive_with_feedforward (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  psd_pkg::t_in                      i_in,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output psd_pkg::t_out                     o_out,
    // Configuration channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import psd_pkg::*;

    `include "pid_speed_drive_with_feedforward_assert.svh"

    t_cfg w_cfg;

    psd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ------------------------------------------------------------------
    // Stage valid bits and the ready chain. A stage can take new data
    // when it is empty or when its contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic w_rdy_out, w_rdy3, w_rdy2, w_rdy1;

    assign w_rdy_out = !r_out_v || !i_out_stall;
    assign w_rdy3    = !r_s3_v  || w_rdy_out;
    assign w_rdy2    = !r_s2_v  || w_rdy3;
    assign w_rdy1    = !r_s1_v  || w_rdy2;

    assign o_in_stall = !w_rdy1;

    logic w_in_fire, w_s1_fire, w_s2_fire, w_s3_fire;
    assign w_in_fire = i_in_valid && w_rdy1;
    assign w_s1_fire = r_s1_v && w_rdy2;
    assign w_s2_fire = r_s2_v && w_rdy3;
    assign w_s3_fire = r_s3_v && w_rdy_out;

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    t_in r_s1;

    // ------------------------------------------------------------------
    // Stage 2: error, saturated error sum and derivative. The loop state
    // is updated here, once per transaction and in arrival order.
    // ------------------------------------------------------------------
    logic signed [16:0] r_esum;
    logic signed [16:0] r_prev_err;

    logic signed [16:0] w_err;
    logic signed [18:0] w_sum_raw;
    logic signed [18:0] w_ilim;
    logic signed [16:0] w_esum;
    logic signed [17:0] w_deriv;

    assign w_err     = {r_s1.target[15], r_s1.target} - {r_s1.measure[15], r_s1.measure};
    assign w_sum_raw = {{2{r_esum[16]}}, r_esum} + {{2{w_err[16]}}, w_err};
    assign w_ilim    = $signed({3'b000, w_cfg.integral_limit});
    assign w_deriv   = {w_err[16], w_err} - {r_prev_err[16], r_prev_err};

    always_comb begin
        if (w_sum_raw > w_ilim) begin
            w_esum = w_ilim[16:0];
        end else if (w_sum_raw < -w_ilim) begin
            w_esum = 17'(-w_ilim);
        end else begin
            w_esum = w_sum_raw[16:0];
        end
    end

    logic signed [15:0] r_s2_target;
    logic signed [16:0] r_s2_err;
    logic signed [16:0] r_s2_esum;
    logic signed [17:0] r_s2_deriv;

    // ------------------------------------------------------------------
    // Stage 3: the four gain products, each exact.
    // ------------------------------------------------------------------
    logic signed [31:0] r_prod_ff;
    logic signed [32:0] r_prod_p;
    logic signed [32:0] r_prod_i;
    logic signed [33:0] r_prod_d;

    // ------------------------------------------------------------------
    // Result stage: exact sum, floor shift by 8, clamp, direction logic.
    // Dropping the low eight bits of a two's complement value is the
    // floor of the division by 256.
    // ------------------------------------------------------------------
    logic signed [35:0] w_acc;
    logic signed [27:0] w_shift;
    logic signed [27:0] w_olim;
    logic signed [15:0] w_drive;
    logic               w_dir;
    logic signed [15:0] w_neg_drive;
    logic               r_prev_dir;
    t_out               r_out;

    assign w_acc = {{4{r_prod_ff[31]}}, r_prod_ff}
                 + {{3{r_prod_p[32]}},  r_prod_p}
                 + {{3{r_prod_i[32]}},  r_prod_i}
                 + {{2{r_prod_d[33]}},  r_prod_d};
    assign w_shift = w_acc[35:8];
    assign w_olim  = $signed({13'd0, w_cfg.output_limit});

    always_comb begin
        if (w_shift > w_olim) begin
            w_drive = w_olim[15:0];
        end else if (w_shift < -w_olim) begin
            w_drive = 16'(-w_olim);
        end else begin
            w_drive = w_shift[15:0];
        end
    end

    assign w_dir       = w_drive[15];
    assign w_neg_drive = -w_drive;

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_esum     <= '0;
            r_prev_err <= '0;
            r_prev_dir <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_v <= i_in_valid;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (w_rdy_out) begin
                r_out_v <= r_s3_v;
            end
            if (w_s1_fire) begin
                r_esum     <= w_esum;
                r_prev_err <= w_err;
            end
            if (w_s3_fire) begin
                r_prev_dir <= w_dir;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers, loaded only when their stage takes new data.
    // Both factors of each product are sign extended to the product width.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1 <= i_in;
        end
        if (w_s1_fire) begin
            r_s2_target <= r_s1.target;
            r_s2_err    <= w_err;
            r_s2_esum   <= w_esum;
            r_s2_deriv  <= w_deriv;
        end
        if (w_s2_fire) begin
            r_prod_ff <= 32'($signed(w_cfg.ff_gain)) * 32'(r_s2_target);
            r_prod_p  <= 33'($signed(w_cfg.p_gain))  * 33'(r_s2_err);
            r_prod_i  <= 33'($signed(w_cfg.i_gain))  * 33'(r_s2_esum);
            r_prod_d  <= 34'($signed(w_cfg.d_gain))  * 34'(r_s2_deriv);
        end
        if (w_s3_fire) begin
            r_out.drive     <= w_drive;
            r_out.direction <= w_dir;
            r_out.magnitude <= w_dir ? w_neg_drive[14:0] : w_drive[14:0];
            r_out.reversal  <= w_dir != r_prev_dir;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `PSD_ASSERT_NEXT(a_esum_bounded, i_clk, i_rst_n, w_s1_fire,
        (r_s2_esum <= $signed({1'b0, w_cfg.integral_limit}))
        && (r_s2_esum >= -$signed({1'b0, w_cfg.integral_limit})),
        "error sum left its saturation bound")
    `PSD_ASSERT_NEXT(a_drive_bounded, i_clk, i_rst_n, w_s3_fire,
        (o_out.drive <= $signed({1'b0, w_cfg.output_limit}))
        && (o_out.drive >= -$signed({1'b0, w_cfg.output_limit})),
        "drive left its saturation bound")
    `PSD_ASSERT_NEXT(a_reversal_tracks, i_clk, i_rst_n, w_s3_fire,
        o_out.reversal == (o_out.direction != $past(r_prev_dir)),
        "reversal flag does not match the previous direction")
    `PSD_ASSERT_SAME(a_empty_never_stalls, i_clk, i_rst_n,
        !r_s1_v && !r_s2_v && !r_s3_v && !r_out_v, !o_in_stall,
        "empty pipeline stalls the input")

endmodule

/* sv/psd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Speed drive configuration registers
// Holds the four gains and the two saturation bounds written over the port.
// ----------------------------------------------------------------------------
module psd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output psd_pkg::t_cfg                     o_cfg
);
    import psd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes never wait.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FF_GAIN: n_cfg.ff_gain        = $signed(i_cfg_data);
                CFG_P_GAIN:  n_cfg.p_gain         = $signed(i_cfg_data);
                CFG_I_GAIN:  n_cfg.i_gain         = $signed(i_cfg_data);
                CFG_D_GAIN:  n_cfg.d_gain         = $signed(i_cfg_data);
                CFG_ILIMIT:  n_cfg.integral_limit = i_cfg_data;
                CFG_OLIMIT:  n_cfg.output_limit   = i_cfg_data[OLIM_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ff_gain        <= '0;
            r_cfg.p_gain         <= '0;
            r_cfg.i_gain         <= '0;
            r_cfg.d_gain         <= '0;
            r_cfg.integral_limit <= ILIM_RESET;
            r_cfg.output_limit   <= OLIM_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
